FILE: sv/rc_channel_mixer_core_defines.svh
// Assertion helpers for the mixer RTL.
`ifndef RC_CHANNEL_MIXER_CORE_DEFINES_SVH
`define RC_CHANNEL_MIXER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RCM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/rcm_pkg.sv
`timescale 1ns / 1ps

package rcm_pkg;

  localparam int NUM_STICKS = 5;
  localparam int STICK_W    = 11;
  localparam int COEF_W     = 8;
  localparam int EPA_HIGH_W = 7;
  localparam int PULSE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIX_COEF_0    = 3'd0,
    REG_MIX_COEF_1    = 3'd1,
    REG_MIX_COEF_2    = 3'd2,
    REG_MIX_COEF_3    = 3'd3,
    REG_MIX_COEF_4    = 3'd4,
    REG_ENDPOINT_LOW  = 3'd5,
    REG_ENDPOINT_HIGH = 3'd6,
    REG_TRIM_OFFSET   = 3'd7
  } cfg_reg_e;

  localparam logic signed [COEF_W-1:0]     COEF_0_RST        = 8'sd10;
  localparam logic signed [COEF_W-1:0]     ENDPOINT_LOW_RST  = -8'sd100;
  localparam logic        [EPA_HIGH_W-1:0] ENDPOINT_HIGH_RST = 7'd100;

endpackage

FILE: sv/rcm_if.sv
`timescale 1ns / 1ps

// Stick vector channel.
interface rcm_stick_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rcm_pkg::STICK_W-1:0]   stick_0;
  logic signed [rcm_pkg::STICK_W-1:0]   stick_1;
  logic signed [rcm_pkg::STICK_W-1:0]   stick_2;
  logic signed [rcm_pkg::STICK_W-1:0]   stick_3;
  logic signed [rcm_pkg::STICK_W-1:0]   stick_4;

  modport source (output valid, stick_0, stick_1, stick_2, stick_3, stick_4, input ready);
  modport sink   (input valid, stick_0, stick_1, stick_2, stick_3, stick_4, output ready);
endinterface

// Pulse width channel.
interface rcm_pulse_if;
  logic                          valid;
  logic                          ready;
  logic [rcm_pkg::PULSE_W-1:0]   pulse_width;

  modport source (output valid, pulse_width, input ready);
  modport sink   (input valid, pulse_width, output ready);
endinterface

FILE: sv/rcm_div_pipe.sv
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per stage, NUM_W stages.
// All stages advance together on en_i.
module rcm_div_pipe #(
  parameter int NUM_W  = 31,
  parameter int DEN_W  = 10,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W-1:0]             valid_q;
  logic [NUM_W-1:0][DEN_W-1:0]  rem_q;
  logic [NUM_W-1:0][NUM_W-1:0]  nq_q;   // numerator bits still to shift in, quotient bits below
  logic [NUM_W-1:0][DEN_W-1:0]  den_q;
  logic [NUM_W-1:0][SIDE_W-1:0] side_q;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              valid_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign nq_in    = num_i;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign nq_in    = nq_q[s-1];
      assign den_in   = den_q[s-1];
      assign side_in  = side_q[s-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_in});
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_q[s]   <= {nq_in[NUM_W-2:0], fits};
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NUM_W-1];
  assign quot_o  = nq_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

FILE: sv/rc_channel_mixer_core.sv
`timescale 1ns / 1ps

// RC channel mixer: turns one vector of five signed stick positions into the servo pulse
// width of one output channel. Each stick is weighted by its mix coefficient, the sum is
// scaled by DEFLECTION_TICKS, divided by the sum of the absolute coefficients, multiplied
// by the high endpoint (sum zero or more) or the negated low endpoint, divided by
// ENDPOINT_FULL * INPUT_NORM and added to CENTER_TICKS + trim_offset * TRIM_STEP; both
// divisions truncate toward zero and the result saturates to 0..65535. With all
// coefficients zero the output is the trimmed centre. A new stick vector is taken every
// cycle while the skid entry is empty; it goes through product, sum and scale registers and
// a bit-per-stage divider by the coefficient sum, whose depth is set by MAG1_W, the
// width of the scaled sum. The division by ENDPOINT_FULL * INPUT_NORM is a single
// stage of reciprocal multiplication. An output register and a one-entry skid buffer
// sit at the end, so input keeps flowing while a result waits; the pipeline halts only
// once the skid entry is full. Configuration registers are written through cfg_we_i /
// cfg_idx_i / cfg_data_i and must only change while the pipeline holds no item.

`include "rc_channel_mixer_core_defines.svh"

module rc_channel_mixer_core #(
  parameter int INPUT_COUNT      = 5,
  parameter int INPUT_NORM       = 1000,
  parameter int ENDPOINT_FULL    = 100,
  parameter int CENTER_TICKS     = 1500,
  parameter int DEFLECTION_TICKS = 500,
  parameter int TRIM_STEP        = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  rcm_stick_if.sink                          in_i,
  rcm_pulse_if.source                        out_o
);

  // Only the sticks that exist are mixed.
  localparam int NUSED   = (INPUT_COUNT < rcm_pkg::NUM_STICKS) ? INPUT_COUNT
                                                               : rcm_pkg::NUM_STICKS;
  localparam int PROD_W  = rcm_pkg::STICK_W + rcm_pkg::COEF_W;
  localparam int SUM_W   = PROD_W + $clog2(NUSED);
  localparam int ABS_W   = rcm_pkg::COEF_W + $clog2(NUSED);
  localparam int DEFL_W  = $clog2(DEFLECTION_TICKS + 1);
  localparam int MAG1_W  = SUM_W + DEFL_W;
  localparam int EPA_W   = rcm_pkg::COEF_W;
  // |sum| never exceeds stick full scale times the coefficient magnitude sum, so the
  // first quotient is at most DEFLECTION_TICKS * 1024; the endpoint factor is at most 128.
  localparam longint MAG2_MAX = longint'(DEFLECTION_TICKS)
                                << (rcm_pkg::STICK_W + rcm_pkg::COEF_W - 2);
  localparam int MAG2_W  = $clog2(MAG2_MAX + 1);
  localparam int END_DIV = ENDPOINT_FULL * INPUT_NORM;
  // Rounded-up reciprocal, exact for every numerator below 2**MAG2_W.
  localparam int     DIV2_SH = MAG2_W + $clog2(END_DIV);
  localparam longint RECIP   = ((longint'(1) << DIV2_SH) + longint'(END_DIV) - 1)
                               / longint'(END_DIV);
  localparam int     RECIP_W = $clog2(RECIP + 1);
  localparam int     RPROD_W = MAG2_W + RECIP_W;
  localparam int     QUOT2_W = RPROD_W - DIV2_SH;
  localparam int RES_W   = MAG2_W + 2;
  localparam logic signed [RES_W-1:0] PULSE_MAX = RES_W'((1 << rcm_pkg::PULSE_W) - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [rcm_pkg::COEF_W-1:0]     coef_q [rcm_pkg::NUM_STICKS];
  logic signed [rcm_pkg::COEF_W-1:0]     endpoint_low_q;
  logic        [rcm_pkg::EPA_HIGH_W-1:0] endpoint_high_q;
  logic signed [rcm_pkg::COEF_W-1:0]     trim_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rcm_pkg::NUM_STICKS; i++) begin
        coef_q[i] <= '0;
      end
      coef_q[0]       <= rcm_pkg::COEF_0_RST;
      endpoint_low_q  <= rcm_pkg::ENDPOINT_LOW_RST;
      endpoint_high_q <= rcm_pkg::ENDPOINT_HIGH_RST;
      trim_offset_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (rcm_pkg::cfg_reg_e'(cfg_idx_i))
        rcm_pkg::REG_MIX_COEF_0:    coef_q[0]       <= cfg_data_i;
        rcm_pkg::REG_MIX_COEF_1:    coef_q[1]       <= cfg_data_i;
        rcm_pkg::REG_MIX_COEF_2:    coef_q[2]       <= cfg_data_i;
        rcm_pkg::REG_MIX_COEF_3:    coef_q[3]       <= cfg_data_i;
        rcm_pkg::REG_MIX_COEF_4:    coef_q[4]       <= cfg_data_i;
        rcm_pkg::REG_ENDPOINT_LOW:  endpoint_low_q  <= cfg_data_i;
        rcm_pkg::REG_ENDPOINT_HIGH: endpoint_high_q <= cfg_data_i[rcm_pkg::EPA_HIGH_W-1:0];
        rcm_pkg::REG_TRIM_OFFSET:   trim_offset_q   <= cfg_data_i;
      endcase
    end
  end

  // Derived from config alone; unenforced, the user keeps them stable with items in flight.
  logic [ABS_W-1:0]          abs_sum;
  logic                      coef_all_zero;
  logic signed [RES_W-1:0]   base_ticks;

  // Magnitude taken unsigned, so a weight of -128 counts as 128.
  always_comb begin
    abs_sum = '0;
    for (int i = 0; i < NUSED; i++) begin
      abs_sum = abs_sum + (coef_q[i][rcm_pkg::COEF_W-1] ? ABS_W'($unsigned(-coef_q[i]))
                                                        : ABS_W'(coef_q[i]));
    end
  end

  assign coef_all_zero = (abs_sum == '0);
  assign base_ticks    = RES_W'(CENTER_TICKS) + RES_W'(trim_offset_q) * RES_W'(TRIM_STEP);

  // ---------------------------------------------------------------------------
  // Pipeline control: everything advances unless the skid entry is occupied.
  // ---------------------------------------------------------------------------
  logic                          en;
  logic                          out_valid_q;
  logic [rcm_pkg::PULSE_W-1:0]   out_q;
  logic                          skid_valid_q;
  logic [rcm_pkg::PULSE_W-1:0]   skid_q;

  assign en         = !skid_valid_q;
  assign in_i.ready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: per-stick products
  // ---------------------------------------------------------------------------
  logic signed [rcm_pkg::STICK_W-1:0] stick [rcm_pkg::NUM_STICKS];
  logic signed [PROD_W-1:0]           prod_q [NUSED];
  logic                               v1_q;

  assign stick[0] = in_i.stick_0;
  assign stick[1] = in_i.stick_1;
  assign stick[2] = in_i.stick_2;
  assign stick[3] = in_i.stick_3;
  assign stick[4] = in_i.stick_4;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUSED; i++) begin
        prod_q[i] <= PROD_W'(stick[i]) * PROD_W'(coef_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: weighted sum
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_d;
  logic signed [SUM_W-1:0] sum_q;
  logic                    v2_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUSED; i++) begin
      sum_d = sum_d + SUM_W'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sign and magnitude, scale by deflection
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]  sum_mag;
  logic [MAG1_W-1:0] mag1_q;
  logic              neg1_q;
  logic              v3_q;

  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q <= MAG1_W'(sum_mag) * MAG1_W'(DEFLECTION_TICKS);
      neg1_q <= sum_q[SUM_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divide by the sum of absolute coefficients
  // ---------------------------------------------------------------------------
  logic              div1_valid;
  logic [MAG1_W-1:0] quot1;
  logic [0:0]        neg_div1;

  rcm_div_pipe #(
    .NUM_W  (MAG1_W),
    .DEN_W  (ABS_W),
    .SIDE_W (1)
  ) u_div_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (mag1_q),
    .den_i   (abs_sum),
    .side_i  (neg1_q),
    .valid_o (div1_valid),
    .quot_o  (quot1),
    .side_o  (neg_div1)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: endpoint factor. Negative side uses minus endpoint_low, which turns
  // negative for a positive endpoint_low and so flips the sign back.
  // ---------------------------------------------------------------------------
  logic [EPA_W-1:0]  epa_mag;
  logic              low_positive;
  logic [MAG2_W-1:0] mag2_q;
  logic              neg2_q;
  logic              v4_q;

  assign low_positive = !endpoint_low_q[rcm_pkg::COEF_W-1] && (endpoint_low_q != '0);

  always_comb begin
    if (!neg_div1[0]) begin
      epa_mag = EPA_W'(endpoint_high_q);
    end else if (endpoint_low_q[rcm_pkg::COEF_W-1]) begin
      epa_mag = EPA_W'(-endpoint_low_q);
    end else begin
      epa_mag = EPA_W'(endpoint_low_q);
    end
  end

  // The quotient fits MAG2_W bits whenever a coefficient is set; drop the rest.
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag2_q <= coef_all_zero ? '0 : MAG2_W'(quot1) * MAG2_W'(epa_mag);
      neg2_q <= neg_div1[0] && !low_positive;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= div1_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: divide by full endpoint times input norm through the reciprocal;
  // the quotient is the top of the product.
  // ---------------------------------------------------------------------------
  logic [RPROD_W-1:0] recip_q;
  logic               neg5_q;
  logic               v5_q;
  logic [QUOT2_W-1:0] quot2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      recip_q <= RPROD_W'(mag2_q) * RPROD_W'(RECIP);
      neg5_q  <= neg2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  assign quot2 = recip_q[DIV2_SH +: QUOT2_W];

  // ---------------------------------------------------------------------------
  // Stage 6: apply sign and add trimmed centre
  // ---------------------------------------------------------------------------
  logic signed [RES_W-1:0] quot2_s;
  logic signed [RES_W-1:0] val_q;
  logic                    val_valid_q;

  assign quot2_s = RES_W'(quot2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= neg5_q ? base_ticks - quot2_s : base_ticks + quot2_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_valid_q <= 1'b0;
    end else if (en) begin
      val_valid_q <= v5_q;
    end
  end

  // Saturate to the pulse width range.
  logic [rcm_pkg::PULSE_W-1:0] pulse_d;

  always_comb begin
    if (val_q < 0) begin
      pulse_d = '0;
    end else if (val_q > PULSE_MAX) begin
      pulse_d = '1;
    end else begin
      pulse_d = val_q[rcm_pkg::PULSE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid entry. A finished result goes to the output
  // register if it is free or being transferred, otherwise into the skid entry.
  // ---------------------------------------------------------------------------
  logic out_take;

  assign out_take = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (val_valid_q) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (val_valid_q) begin
      if (!out_valid_q || out_take) begin
        out_q <= pulse_d;
      end else begin
        skid_q <= pulse_d;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pulse_width = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RCM_ASSERT(a_skid_implies_out, skid_valid_q |-> out_valid_q, "skid entry full while output empty")
  `RCM_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_q) |-> $past(out_valid_q && !out_o.ready), "skid entry filled without output stall")
  `RCM_ASSERT(a_result_lands, (!skid_valid_q && val_valid_q && !(out_valid_q && !out_o.ready)) |=> (out_valid_q && out_q == $past(pulse_d)), "finished result not moved to output")

endmodule

FILE: test/rc_channel_mixer_core_tb.sv
`timescale 1ns / 1ps

module rc_channel_mixer_core_tb;

  // Block parameters; the DUT is built with the same values.
  localparam int INPUT_COUNT      = 5;
  localparam int INPUT_NORM       = 1000;
  localparam int ENDPOINT_FULL    = 100;
  localparam int CENTER_TICKS     = 1500;
  localparam int DEFLECTION_TICKS = 500;
  localparam int TRIM_STEP        = 1;

  // Allow a margin on top of the pipeline depth when draining.
  localparam int SETTLE_CYCLES = 100;
  // Cycle limit, taken several times over the slowest legal run.
  localparam int CYCLE_LIMIT   = 250000;
  localparam int MAX_GAP       = 15;

  typedef logic [rcm_pkg::NUM_STICKS-1:0][rcm_pkg::STICK_W-1:0] stick_vec_t;

  // One complete set of mixer registers, mirrored on the testbench side.
  typedef struct packed {
    logic [rcm_pkg::NUM_STICKS-1:0][rcm_pkg::COEF_W-1:0] coef;
    logic [rcm_pkg::COEF_W-1:0]                          ep_low;
    logic [rcm_pkg::EPA_HIGH_W-1:0]                      ep_high;
    logic [rcm_pkg::COEF_W-1:0]                          trim;
  } mix_setting_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [rcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rcm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  rcm_stick_if stick_ch ();
  rcm_pulse_if pulse_ch ();

  rc_channel_mixer_core #(
    .INPUT_COUNT      (INPUT_COUNT),
    .INPUT_NORM       (INPUT_NORM),
    .ENDPOINT_FULL    (ENDPOINT_FULL),
    .CENTER_TICKS     (CENTER_TICKS),
    .DEFLECTION_TICKS (DEFLECTION_TICKS),
    .TRIM_STEP        (TRIM_STEP)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (stick_ch),
    .out_o      (pulse_ch)
  );

  // Register copy used by the pulse predictor, kept in step with every write.
  mix_setting_t                  mix_cfg;
  // Pulse widths still owed by the block, oldest first.
  logic [rcm_pkg::PULSE_W-1:0]   expected_pulses[$];
  int                            error_count     = 0;
  int                            cycle_count     = 0;
  // Traffic shaping: bursts with no idling, and one long receiver hold-off.
  bit                            send_no_gaps    = 1'b0;
  bit                            recv_no_stalls  = 1'b0;
  int                            hold_off_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stop a hung run; anything still owed at this point is a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pulses.size());
      $display("rc_channel_mixer_core_tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: pulse_width %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Pulse width for one stick vector under the current register copy. All arithmetic
  // is 64-bit signed, so nothing wraps before the final saturation; SystemVerilog
  // division of signed operands truncates toward zero, matching the block.
  function automatic logic [rcm_pkg::PULSE_W-1:0] predict_pulse(input stick_vec_t sticks);
    longint weighted_sum;
    longint coef_abs_sum;
    longint coef;
    longint epa_factor;
    longint scaled;
    longint pulse;
    int     i;
    weighted_sum = 0;
    coef_abs_sum = 0;
    for (i = 0; i < rcm_pkg::NUM_STICKS; i++) begin
      // Sticks above the configured input count take no part.
      if (i < INPUT_COUNT) begin
        coef          = longint'($signed(mix_cfg.coef[i]));
        coef_abs_sum += (coef < 0) ? -coef : coef;
        weighted_sum += longint'($signed(sticks[i])) * coef;
      end
    end
    // A positive low endpoint is negated as is, giving a negative factor.
    epa_factor = (weighted_sum >= 0) ? longint'(mix_cfg.ep_high)
                                     : -longint'($signed(mix_cfg.ep_low));
    pulse = longint'(CENTER_TICKS) + longint'($signed(mix_cfg.trim)) * longint'(TRIM_STEP);
    // All coefficients zero: trimmed centre only, no division.
    if (coef_abs_sum != 0) begin
      scaled  = longint'(DEFLECTION_TICKS) * weighted_sum;
      scaled  = scaled / coef_abs_sum;
      scaled  = scaled * epa_factor;
      scaled  = scaled / (longint'(ENDPOINT_FULL) * longint'(INPUT_NORM));
      pulse  += scaled;
    end
    if (pulse < 0) pulse = 0;
    if (pulse > 65535) pulse = 65535;
    return pulse[rcm_pkg::PULSE_W-1:0];
  endfunction

  function automatic mix_setting_t uniform_setting(
      input logic [rcm_pkg::COEF_W-1:0]     coef,
      input logic [rcm_pkg::COEF_W-1:0]     ep_low,
      input logic [rcm_pkg::EPA_HIGH_W-1:0] ep_high,
      input logic [rcm_pkg::COEF_W-1:0]     trim);
    mix_setting_t s;
    int           i;
    for (i = 0; i < rcm_pkg::NUM_STICKS; i++) s.coef[i] = coef;
    s.ep_low  = ep_low;
    s.ep_high = ep_high;
    s.trim    = trim;
    return s;
  endfunction

  function automatic stick_vec_t same_sticks(input logic [rcm_pkg::STICK_W-1:0] pos);
    stick_vec_t v;
    int         i;
    for (i = 0; i < rcm_pkg::NUM_STICKS; i++) v[i] = pos;
    return v;
  endfunction

  function automatic logic [rcm_pkg::COEF_W-1:0] random_coef();
    int pick;
    pick = $urandom_range(0, 5);
    case (pick)
      0:       return '0;
      1:       return rcm_pkg::COEF_W'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 8'h7f;
          1:       return 8'h80;
          2:       return rcm_pkg::COEF_W'(100);
          default: return rcm_pkg::COEF_W'(-100);
        endcase
      end
      default: return rcm_pkg::COEF_W'(int'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  function automatic mix_setting_t random_setting();
    mix_setting_t s;
    int           i;
    for (i = 0; i < rcm_pkg::NUM_STICKS; i++) s.coef[i] = random_coef();
    // Now and then no coefficient at all.
    if ($urandom_range(0, 5) == 0) s.coef = '0;
    s.ep_low  = ($urandom_range(0, 3) == 0) ? rcm_pkg::COEF_W'($urandom)
                                            : rcm_pkg::COEF_W'(-int'($urandom_range(0, 100)));
    s.ep_high = ($urandom_range(0, 3) == 0) ? rcm_pkg::EPA_HIGH_W'($urandom)
                                            : rcm_pkg::EPA_HIGH_W'($urandom_range(0, 100));
    s.trim    = ($urandom_range(0, 3) == 0) ? rcm_pkg::COEF_W'($urandom)
                                            : rcm_pkg::COEF_W'(int'($urandom_range(0, 200)) - 100);
    return s;
  endfunction

  function automatic stick_vec_t random_sticks();
    stick_vec_t v;
    int         i;
    for (i = 0; i < rcm_pkg::NUM_STICKS; i++) begin
      case ($urandom_range(0, 4))
        0:       v[i] = rcm_pkg::STICK_W'($urandom);
        1: begin
          case ($urandom_range(0, 4))
            0:       v[i] = 11'h3ff;
            1:       v[i] = 11'h400;
            2:       v[i] = rcm_pkg::STICK_W'(1000);
            3:       v[i] = rcm_pkg::STICK_W'(-1000);
            default: v[i] = '0;
          endcase
        end
        2:       v[i] = rcm_pkg::STICK_W'(int'($urandom_range(0, 20)) - 10);
        default: v[i] = rcm_pkg::STICK_W'(int'($urandom_range(0, 2000)) - 1000);
      endcase
    end
    return v;
  endfunction

  // Present one stick vector and hold it until the transfer; record the pulse it owes.
  // Valid stays high on return so that a back-to-back vector never drops it.
  task automatic send_sticks(input stick_vec_t sticks);
    int gap;
    gap = send_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      stick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    stick_ch.valid   <= 1'b1;
    stick_ch.stick_0 <= sticks[0];
    stick_ch.stick_1 <= sticks[1];
    stick_ch.stick_2 <= sticks[2];
    stick_ch.stick_3 <= sticks[3];
    stick_ch.stick_4 <= sticks[4];
    @(posedge clk_i);
    while (!stick_ch.ready) @(posedge clk_i);
    expected_pulses.push_back(predict_pulse(sticks));
  endtask

  // Drop valid and wait until every owed pulse has come out.
  task automatic wait_pipeline_empty();
    @(negedge clk_i);
    stick_ch.valid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk_i);
  endtask

  // Write all eight registers back to back; only call with the pipeline empty.
  task automatic apply_mix_setting(input mix_setting_t s);
    int i;
    for (i = 0; i < rcm_pkg::NUM_STICKS; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= rcm_pkg::cfg_reg_e'(int'(rcm_pkg::REG_MIX_COEF_0) + i);
      cfg_data_i <= s.coef[i];
    end
    @(negedge clk_i);
    cfg_idx_i  <= rcm_pkg::REG_ENDPOINT_LOW;
    cfg_data_i <= s.ep_low;
    // Bit seven of the high endpoint write is not stored; toggle it anyway.
    @(negedge clk_i);
    cfg_idx_i  <= rcm_pkg::REG_ENDPOINT_HIGH;
    cfg_data_i <= {1'($urandom), s.ep_high};
    @(negedge clk_i);
    cfg_idx_i  <= rcm_pkg::REG_TRIM_OFFSET;
    cfg_data_i <= s.trim;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    mix_cfg     = s;
  endtask

  // Reset values: stick zero at weight ten, endpoints at full travel, no trim.
  task automatic test_reset_defaults();
    send_sticks(same_sticks(11'h3ff));
    send_sticks(same_sticks(11'h400));
    send_sticks(same_sticks('0));
    send_sticks(same_sticks(rcm_pkg::STICK_W'(1000)));
    send_sticks(same_sticks(rcm_pkg::STICK_W'(-1000)));
    wait_pipeline_empty();
  endtask

  // No coefficients: the output is the trimmed centre, trim at both extremes.
  task automatic test_zero_coefs();
    apply_mix_setting(uniform_setting('0, rcm_pkg::COEF_W'(-100),
                                      rcm_pkg::EPA_HIGH_W'(100), 8'h7f));
    send_sticks(same_sticks(11'h3ff));
    send_sticks(same_sticks(11'h400));
    wait_pipeline_empty();
    apply_mix_setting(uniform_setting('0, rcm_pkg::COEF_W'(-100),
                                      rcm_pkg::EPA_HIGH_W'(100), 8'h80));
    send_sticks(random_sticks());
    wait_pipeline_empty();
  endtask

  // Low endpoint at -128 and positive; high endpoint at its top and at zero; a sum of
  // exactly zero takes the high endpoint.
  task automatic test_endpoint_corners();
    mix_setting_t s;
    s         = uniform_setting(rcm_pkg::COEF_W'(50), 8'h80, 7'h7f, '0);
    s.coef[3] = rcm_pkg::COEF_W'(-30);
    apply_mix_setting(s);
    send_sticks(same_sticks(11'h3ff));
    send_sticks(same_sticks(11'h400));
    send_sticks(same_sticks('0));
    wait_pipeline_empty();
    s.ep_low  = 8'h7f;
    s.ep_high = '0;
    apply_mix_setting(s);
    send_sticks(same_sticks(11'h3ff));
    send_sticks(same_sticks(11'h400));
    wait_pipeline_empty();
  endtask

  // Coefficients at both 8-bit extremes, alone and mixed.
  task automatic test_coef_extremes();
    mix_setting_t s;
    apply_mix_setting(uniform_setting(8'h7f, rcm_pkg::COEF_W'(-100),
                                      rcm_pkg::EPA_HIGH_W'(100), rcm_pkg::COEF_W'(5)));
    send_sticks(same_sticks(11'h3ff));
    send_sticks(same_sticks(11'h400));
    wait_pipeline_empty();
    s         = uniform_setting(8'h80, rcm_pkg::COEF_W'(-100),
                                rcm_pkg::EPA_HIGH_W'(100), rcm_pkg::COEF_W'(-5));
    apply_mix_setting(s);
    send_sticks(same_sticks(11'h3ff));
    send_sticks(same_sticks(11'h400));
    wait_pipeline_empty();
    s.coef[1] = 8'h7f;
    s.coef[3] = 8'h7f;
    apply_mix_setting(s);
    send_sticks(same_sticks(11'h3ff));
    wait_pipeline_empty();
  endtask

  // Random register settings, each followed by a batch of random stick vectors under
  // varying idle patterns on both sides.
  task automatic test_random_mix();
    int phase;
    for (phase = 0; phase < 9; phase++) begin
      send_no_gaps   = (phase % 3 == 1) || (phase == 6);
      recv_no_stalls = (phase % 3 == 2) || (phase == 6);
      apply_mix_setting(random_setting());
      repeat (48) send_sticks(random_sticks());
      wait_pipeline_empty();
    end
    send_no_gaps   = 1'b0;
    recv_no_stalls = 1'b0;
  endtask

  // Hold the receiver off for a long stretch while vectors keep coming, so that the
  // pipeline and skid entry fill and the input stalls.
  task automatic test_backpressure();
    apply_mix_setting(random_setting());
    send_no_gaps    = 1'b1;
    recv_no_stalls  = 1'b1;
    hold_off_cycles = 300;
    repeat (120) send_sticks(random_sticks());
    send_no_gaps    = 1'b0;
    recv_no_stalls  = 1'b0;
    wait_pipeline_empty();
  endtask

  // Receiver: draw a stall before each transfer; a pending hold-off is served first.
  initial begin : pulse_receiver
    int stall;
    pulse_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        pulse_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk_i);
        hold_off_cycles = 0;
      end
      stall = recv_no_stalls ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        pulse_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pulse_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!pulse_ch.valid) @(posedge clk_i);
    end
  end

  // Compare every pulse transfer against the oldest owed pulse width.
  always @(posedge clk_i) begin : pulse_checker
    logic [rcm_pkg::PULSE_W-1:0] want;
    if (rst_ni && pulse_ch.valid && pulse_ch.ready) begin
      if (expected_pulses.size() == 0) begin
        report_mismatch("unexpected result", int'(pulse_ch.pulse_width), -1);
      end else begin
        want = expected_pulses.pop_front();
        if (pulse_ch.pulse_width !== want)
          report_mismatch("pulse_width mismatch", int'(pulse_ch.pulse_width), int'(want));
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = rcm_pkg::REG_MIX_COEF_0;
    cfg_data_i       = '0;
    stick_ch.valid   = 1'b0;
    stick_ch.stick_0 = '0;
    stick_ch.stick_1 = '0;
    stick_ch.stick_2 = '0;
    stick_ch.stick_3 = '0;
    stick_ch.stick_4 = '0;
    mix_cfg          = uniform_setting('0, rcm_pkg::ENDPOINT_LOW_RST,
                                       rcm_pkg::ENDPOINT_HIGH_RST, '0);
    mix_cfg.coef[0]  = rcm_pkg::COEF_0_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_zero_coefs();
    test_endpoint_corners();
    test_coef_extremes();
    test_random_mix();
    test_backpressure();

    // Everything owed has arrived; give stray transfers time to show up.
    wait_pipeline_empty();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("rc_channel_mixer_core_tb OK");
    end else begin
      $display("rc_channel_mixer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
